@@ rtl/core/bccm_pkg.sv @@
// Shared definitions for the bounded coin change block: widths, denominations,
// controller state encoding and the command/status groups between controller and datapath.
// No dependencies.
`default_nettype none

package bccm_pkg;

    localparam int CNT_W              = 10;
    localparam int ROW_W              = 11;
    localparam int DENOM_COUNT        = 4;
    localparam int DENOM_W            = 2;
    localparam int VALUE_W            = 5;
    localparam int MAX_AMOUNT_DEFAULT = 1023;

    // All-ones entry marks an amount that cannot be made.
    localparam logic [ROW_W-1:0] UNREACH = '1;

    localparam logic [DENOM_W-1:0] LAST_DENOM = DENOM_W'(DENOM_COUNT - 1);

    function automatic logic [VALUE_W-1:0] denom_value(input logic [DENOM_W-1:0] idx);
        logic [VALUE_W-1:0] v;
        unique case (idx)
            2'd0:    v = 5'd1;
            2'd1:    v = 5'd5;
            2'd2:    v = 5'd10;
            default: v = 5'd25;
        endcase
        return v;
    endfunction

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_INIT   = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef struct packed {
        logic start;
        logic init_wr;
        logic load;
        logic scan;
        logic write;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic init_last;
        logic cand;
        logic j_zero;
        logic last_denom;
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/bccm_if.sv @@
// Valid/ready channel interfaces for the query and answer items.
// Depends on bccm_pkg for field widths.
`default_nettype none

interface bccm_query_if import bccm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_pennies;
    logic [CNT_W-1:0] count_nickels;
    logic [CNT_W-1:0] count_dimes;
    logic [CNT_W-1:0] count_quarters;
    logic [CNT_W-1:0] target_amount;

    modport source (output valid, count_pennies, count_nickels, count_dimes,
                    count_quarters, target_amount, input ready);
    modport sink   (input valid, count_pennies, count_nickels, count_dimes,
                    count_quarters, target_amount, output ready);
endinterface

interface bccm_answer_if import bccm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] min_coins;
    logic             found;

    modport source (output valid, min_coins, found, input ready);
    modport sink   (input valid, min_coins, found, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bccm_ctrl.sv @@
// Sequencer for the coin change dynamic program: clears the row, walks each
// denomination pass and hands the result to the output register. Depends on bccm_pkg.
`default_nettype none

module bccm_ctrl import bccm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    query_valid,
    output logic         query_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        query_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                query_ready = 1'b1;
                if (query_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (status.bad)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.init_wr = 1'b1;
                    if (status.init_last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!status.cand)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (status.j_zero && status.last_denom)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/bccm_datapath.sv @@
// Datapath for the coin change dynamic program: row memory, amount and
// multiplicity counters, best-count accumulator and output register. Depends on bccm_pkg.
`default_nettype none

module bccm_datapath import bccm_pkg::*;
#(
    parameter  int MAX_AMOUNT = MAX_AMOUNT_DEFAULT,
    localparam int DEPTH      = MAX_AMOUNT + 1,
    localparam int AW         = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] count_pennies,
    input  wire logic [CNT_W-1:0] count_nickels,
    input  wire logic [CNT_W-1:0] count_dimes,
    input  wire logic [CNT_W-1:0] count_quarters,
    input  wire logic [CNT_W-1:0] target_amount,
    input  wire cmd_t             cmd,
    output status_t               status,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [CNT_W-1:0]      min_coins,
    output logic                  found
);

    localparam int TW = AW + CNT_W;
    localparam int CW = AW + VALUE_W;

    logic [ROW_W-1:0] row_mem [DEPTH];

    logic [CNT_W-1:0]   count_reg [DENOM_COUNT];
    logic [AW-1:0]      target_reg;
    logic               bad_reg;
    logic [AW-1:0]      init_addr_reg;
    logic [AW-1:0]      j_reg;
    logic [DENOM_W-1:0] d_reg;
    logic [AW-1:0]      cur_addr_reg;
    logic [CNT_W:0]     nk_reg;
    logic               p_valid_reg;
    logic               p_first_reg;
    logic [CNT_W-1:0]   p_k_reg;
    logic [ROW_W-1:0]   rd_data_reg;
    logic [ROW_W-1:0]   best_reg;
    logic [ROW_W-1:0]   best_next;
    logic [ROW_W-1:0]   res_reg;
    logic               out_valid_reg;
    logic [CNT_W-1:0]   min_coins_reg;
    logic               found_reg;

    logic [TW-1:0]      target_wide;
    logic               target_bad;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   limit;
    logic [CW-1:0]      cur_ext;
    logic [CW-1:0]      value_ext;
    logic [AW-1:0]      cand_addr;
    logic               cand;
    logic               re;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [ROW_W-1:0]   wdata;
    logic [ROW_W:0]     sum;
    logic               res_found;

    assign target_wide = TW'(target_amount);
    assign target_bad  = target_wide > TW'(MAX_AMOUNT);

    assign value     = denom_value(d_reg);
    assign limit     = count_reg[d_reg];
    assign cur_ext   = CW'(cur_addr_reg);
    assign value_ext = CW'(value);
    assign cand_addr = AW'(cur_ext - value_ext);
    // Next multiplicity exists while supply lasts and k*value still fits in the amount.
    assign cand      = ({1'b0, limit} >= nk_reg) && (cur_ext >= value_ext);

    assign re    = cmd.load | (cmd.scan & cand);
    assign raddr = cmd.load ? j_reg : cand_addr;

    assign we    = cmd.init_wr | cmd.write;
    assign waddr = cmd.init_wr ? init_addr_reg : j_reg;
    assign wdata = cmd.init_wr ? ((init_addr_reg == '0) ? '0 : UNREACH) : best_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= row_mem[raddr];
        end
    end

    // Fold in the entry returned by the read issued in the previous cycle.
    always_comb
    begin
        best_next = best_reg;
        sum       = {1'b0, rd_data_reg} + (ROW_W + 1)'(p_k_reg);
        if (p_valid_reg)
        begin
            if (p_first_reg)
            begin
                best_next = rd_data_reg;
            end
            else if ((rd_data_reg != UNREACH) && (sum < {1'b0, best_reg}))
            begin
                best_next = sum[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            init_addr_reg <= '0;
            j_reg         <= '0;
            d_reg         <= '0;
            cur_addr_reg  <= '0;
            nk_reg        <= '0;
        end
        else
        begin
            p_valid_reg <= re;
            if (cmd.start)
            begin
                init_addr_reg <= '0;
                j_reg         <= target_wide[AW-1:0];
                d_reg         <= '0;
            end
            if (cmd.init_wr)
            begin
                init_addr_reg <= init_addr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                cur_addr_reg <= j_reg;
                nk_reg       <= (CNT_W + 1)'(1);
            end
            else if (cmd.scan && cand)
            begin
                cur_addr_reg <= cand_addr;
                nk_reg       <= nk_reg + (CNT_W + 1)'(1);
            end
            if (cmd.write)
            begin
                if (j_reg == '0)
                begin
                    j_reg <= target_reg;
                    d_reg <= d_reg + DENOM_W'(1);
                end
                else
                begin
                    j_reg <= j_reg - AW'(1);
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_found = !bad_reg && (res_reg != UNREACH);

    always_ff @(posedge clk)
    begin
        best_reg    <= best_next;
        p_first_reg <= cmd.load;
        p_k_reg     <= nk_reg[CNT_W-1:0];
        if (cmd.start)
        begin
            count_reg[0] <= count_pennies;
            count_reg[1] <= count_nickels;
            count_reg[2] <= count_dimes;
            count_reg[3] <= count_quarters;
            target_reg   <= target_wide[AW-1:0];
            bad_reg      <= target_bad;
        end
        // The last pass writes the target entry first, so the final value lands here.
        if (cmd.write && (j_reg == target_reg))
        begin
            res_reg <= best_next;
        end
        if (cmd.finish)
        begin
            found_reg     <= res_found;
            min_coins_reg <= res_found ? res_reg[CNT_W-1:0] : '0;
        end
    end

    assign status.bad        = bad_reg;
    assign status.init_last  = (init_addr_reg == target_reg);
    assign status.cand       = cand;
    assign status.j_zero     = (j_reg == '0);
    assign status.last_denom = (d_reg == LAST_DENOM);
    assign status.out_full   = out_valid_reg & !out_ready;

    assign out_valid = out_valid_reg;
    assign min_coins = min_coins_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

@@ rtl/core/bounded_coin_change_min.sv @@
// Bounded coin change, fewest coins: one query at a time over a single-port row memory.
// Denomination values v[d] are 1, 5, 10 and 25; for target T each pass walks j = T down to 0
//   with a candidate scan limited by the supply c[d] and by j / v[d],
//   at one memory read per cycle of the candidate scan; the next query is taken
//   once the result sits in the output register. A target above MAX_AMOUNT answers not found.
// Reset clears the controller, the counters and the valid flags; row entries 0 to T are rewritten per in-range query.
`default_nettype none

module bounded_coin_change_min import bccm_pkg::*;
#(
    parameter int MAX_AMOUNT = MAX_AMOUNT_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bccm_query_if.sink    query,
    bccm_answer_if.source answer
);

    cmd_t    cmd;
    status_t status;
    logic    query_ready;

    bccm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query.valid),
        .query_ready (query_ready),
        .status      (status),
        .cmd         (cmd)
    );

    bccm_datapath #(
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .count_pennies  (query.count_pennies),
        .count_nickels  (query.count_nickels),
        .count_dimes    (query.count_dimes),
        .count_quarters (query.count_quarters),
        .target_amount  (query.target_amount),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (answer.ready),
        .out_valid      (answer.valid),
        .min_coins      (answer.min_coins),
        .found          (answer.found)
    );

    assign query.ready = query_ready;

    // A taken query keeps the block busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready) |=> !query.ready)
        else $error("query accepted while a previous query is still in work");

    // An unreachable target always reports a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (answer.valid && !answer.found) |-> (answer.min_coins == '0))
        else $error("not-found answer carries a nonzero coin count");

    // The result is loaded in the same step that frees the block for the next query.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) |-> (answer.valid && query.ready))
        else $error("result loaded without returning to idle");

    // Commands are mutually exclusive.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("controller issued more than one command");

endmodule

`default_nettype wire
